[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RCNT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define RCNT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[rtl/core/rcnt_pkg.sv]
// ----------------------------------------------------------------------------
// rcnt_pkg
// Types, codes and constant tables of the three-channel root counter.
// ----------------------------------------------------------------------------
package rcnt_pkg;

  typedef logic [15:0] cnt_t;
  typedef logic [12:0] mode_t;
  typedef logic [9:0]  cyc_t;
  typedef logic [1:0]  chan_t;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_HBLANK = 2'd3
  } rcnt_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QMUL,
    ST_QFIX,
    ST_BUMP
  } rcnt_state_t;

  localparam logic [3:0] OFF_COUNT  = 4'h0;
  localparam logic [3:0] OFF_MODE   = 4'h4;
  localparam logic [3:0] OFF_TARGET = 4'h8;

  localparam chan_t NUM_CHAN_LAST = 2'd2;
  localparam chan_t CHAN_NONE     = 2'd3;
  localparam chan_t CHAN_HBLANK   = 2'd1;

  localparam mode_t MODE_WR_MASK = 13'h13FF;
  localparam mode_t MODE_HBL     = 13'h0101;
  localparam cnt_t  MODE_RD_FLAG = 16'h0400;
  localparam cnt_t  CNT_MAX      = 16'hFFFF;

  localparam int MODE_EN      = 0;
  localparam int MODE_RST_TGT = 3;
  localparam int MODE_IRQ_TGT = 4;
  localparam int MODE_IRQ_MAX = 5;
  localparam int MODE_SEL     = 8;

  localparam cyc_t MAX_TICK_CYCLES = 10'd1023;

  typedef struct packed {
    rcnt_cmd_t   command;
    logic [5:0]  address;
    logic [15:0] write_data;
    logic [9:0]  tick_cycles;
  } in_req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [2:0]  irq_lines;
  } out_res_t;

  typedef struct packed {
    logic  load;
    chan_t ch;
    logic  sel;
  } quot_ctl_t;

  // Prescaler divisor per channel, by mode bit 8.
  function automatic logic [5:0] div_of(input chan_t ch, input logic sel);
    logic [5:0] d;
    case (ch)
      2'd0:    d = sel ? 6'd1  : 6'd5;
      2'd1:    d = sel ? 6'd39 : 6'd1;
      default: d = sel ? 6'd8  : 6'd1;
    endcase
    return d;
  endfunction

  // Scaled reciprocal (x/1024), never above 1/divisor; error stays below one.
  function automatic logic [10:0] recip_of(input chan_t ch, input logic sel);
    logic [10:0] r;
    case (ch)
      2'd0:    r = sel ? 11'd1024 : 11'd204;
      2'd1:    r = sel ? 11'd26   : 11'd1024;
      default: r = sel ? 11'd128  : 11'd1024;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/rcnt_bump.sv]
// ----------------------------------------------------------------------------
// rcnt_bump
// Shared increment unit: one count step with target and wrap checks.
// ----------------------------------------------------------------------------
module rcnt_bump (
  input  rcnt_pkg::cnt_t  cnt,
  input  rcnt_pkg::cnt_t  tgt,
  input  rcnt_pkg::mode_t mode,
  output rcnt_pkg::cnt_t  cnt_next,
  output logic            irq
);
  import rcnt_pkg::*;

  cnt_t inc;

  always_comb begin
    inc      = cnt + 16'd1;
    cnt_next = inc;
    irq      = 1'b0;
    if (inc == tgt && mode[MODE_IRQ_TGT]) begin
      irq = 1'b1;
      if (mode[MODE_RST_TGT]) begin
        cnt_next = '0;
      end
    end
    // wrap at full scale regardless of the irq enable
    if (cnt_next == CNT_MAX) begin
      if (mode[MODE_IRQ_MAX]) begin
        irq = 1'b1;
      end
      cnt_next = '0;
    end
  end

endmodule

[rtl/core/rcnt_quot.sv]
// ----------------------------------------------------------------------------
// rcnt_quot
// Prescale quotient: registered reciprocal multiply, then one-step fixup.
// ----------------------------------------------------------------------------
module rcnt_quot (
  input  logic                clk,
  input  rcnt_pkg::quot_ctl_t ctl,
  input  rcnt_pkg::cyc_t      cycles,
  output rcnt_pkg::cyc_t      quot
);
  import rcnt_pkg::*;

  logic [20:0] prod;
  cyc_t        q0_r;
  logic [5:0]  dv;
  logic [15:0] qd;
  cyc_t        rem;

  assign prod = {11'b0, cycles} * {10'b0, recip_of(ctl.ch, ctl.sel)};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q0_r <= prod[19:10];
    end
  end

  // estimate is low by at most one
  always_comb begin
    dv   = div_of(ctl.ch, ctl.sel);
    qd   = {6'b0, q0_r} * {10'b0, dv};
    rem  = cycles - qd[9:0];
    quot = q0_r + ((rem >= {4'b0, dv}) ? 10'd1 : 10'd0);
  end

endmodule

[rtl/core/three_channel_root_counter_top.sv]
// ----------------------------------------------------------------------------
// three_channel_root_counter_top
// Three 16-bit root counters with targets, modes and a register bus.
// ----------------------------------------------------------------------------
// Usage: drive in_req and raise start; the request is taken at a rising edge
// where start is high and busy is low. Each request gives one result on
// out_res, marked by out_valid for exactly one cycle; the receiver must take
// it then, there is no back-pressure.
// Reads, writes and hblank events: the result shows in the cycle after the
// request is taken and busy stays low, so a request may follow every cycle.
// Ticks: busy stays high while the sequencer visits each channel in turn: a
// disabled channel passes ST_QMUL only, an enabled one ST_QMUL, ST_QFIX and
// then n ST_BUMP steps, n being that channel's increment count (cycles
// divided by its divisor). The one shared increment unit steps a single
// count per cycle. The result shows in the cycle in which busy falls.
// Reset (rst_n low, synchronous) clears all counts, targets and modes and
// returns the sequencer to idle with no result pending.
// ----------------------------------------------------------------------------
module three_channel_root_counter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rcnt_pkg::in_req_t  in_req,
  output logic               out_valid,
  output rcnt_pkg::out_res_t out_res
);
  import rcnt_pkg::*;
  `include "assert_macros.svh"

  rcnt_state_t state_r, state_nxt;
  chan_t       ch_r, ch_nxt;
  cyc_t        n_r, n_nxt;
  cyc_t        cyc_r, cyc_nxt;
  logic [2:0]  irq_r, irq_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_res_t    out_res_r, out_res_nxt;

  cnt_t  cnt_r  [3];
  cnt_t  tgt_r  [3];
  mode_t mode_r [3];

  chan_t     sel_ch, sel_idx;
  logic      ch_ok;
  logic [3:0] off;
  cnt_t      cnt_sel, tgt_sel;
  mode_t     mode_sel;
  cnt_t      bump_cnt;
  logic      bump_irq;
  logic      wr_cnt_en, wr_tgt_en, wr_mode_en;
  cnt_t      wr_cnt_val;
  logic      chan_done;
  logic [2:0] irq_v, irq_bit;
  quot_ctl_t quot_ctl;
  cyc_t      quot;
  logic      accept;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign off       = in_req.address[3:0];

  // single register-file port: sequencer channel while busy, channel one for hblank, else the request's address
  always_comb begin
    if (busy) begin
      sel_ch = ch_r;
    end else if (in_req.command == CMD_HBLANK) begin
      sel_ch = CHAN_HBLANK;
    end else begin
      sel_ch = in_req.address[5:4];
    end
    ch_ok    = (sel_ch != CHAN_NONE);
    sel_idx  = ch_ok ? sel_ch : 2'd0;
    cnt_sel  = cnt_r[sel_idx];
    tgt_sel  = tgt_r[sel_idx];
    mode_sel = mode_r[sel_idx];
    irq_bit  = 3'b001 << ch_r;
  end

  rcnt_bump u_bump (
    .cnt      (cnt_sel),
    .tgt      (tgt_sel),
    .mode     (mode_sel),
    .cnt_next (bump_cnt),
    .irq      (bump_irq)
  );

  assign quot_ctl.load = (state_r == ST_QMUL) && mode_sel[MODE_EN];
  assign quot_ctl.ch   = ch_r;
  assign quot_ctl.sel  = mode_sel[MODE_SEL];

  rcnt_quot u_quot (
    .clk    (clk),
    .ctl    (quot_ctl),
    .cycles (cyc_r),
    .quot   (quot)
  );

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    n_nxt         = n_r;
    cyc_nxt       = cyc_r;
    irq_nxt       = irq_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '0;
    wr_cnt_en     = 1'b0;
    wr_tgt_en     = 1'b0;
    wr_mode_en    = 1'b0;
    wr_cnt_val    = '0;
    chan_done     = 1'b0;
    irq_v         = irq_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.command)
            CMD_READ: begin
              out_valid_nxt = 1'b1;
              if (ch_ok) begin
                case (off)
                  OFF_COUNT:  out_res_nxt.read_data = cnt_sel;
                  OFF_MODE:   out_res_nxt.read_data = {3'b0, mode_sel} | MODE_RD_FLAG;
                  OFF_TARGET: out_res_nxt.read_data = tgt_sel;
                  default:    out_res_nxt.read_data = '0;
                endcase
              end
            end
            CMD_WRITE: begin
              out_valid_nxt = 1'b1;
              if (ch_ok) begin
                case (off)
                  OFF_COUNT: begin
                    wr_cnt_en  = 1'b1;
                    wr_cnt_val = in_req.write_data;
                  end
                  OFF_MODE: begin
                    wr_mode_en = 1'b1;
                    wr_cnt_en  = 1'b1;
                  end
                  OFF_TARGET: wr_tgt_en = 1'b1;
                  default: ;
                endcase
              end
            end
            CMD_TICK: begin
              cyc_nxt   = (in_req.tick_cycles > MAX_TICK_CYCLES) ? MAX_TICK_CYCLES
                                                                 : in_req.tick_cycles;
              ch_nxt    = '0;
              irq_nxt   = '0;
              state_nxt = ST_QMUL;
            end
            CMD_HBLANK: begin
              out_valid_nxt = 1'b1;
              if ((mode_sel & MODE_HBL) == MODE_HBL) begin
                wr_cnt_en             = 1'b1;
                wr_cnt_val            = bump_cnt;
                out_res_nxt.irq_lines = bump_irq ? 3'b010 : 3'b000;
              end
            end
            default: ;
          endcase
        end
      end
      ST_QMUL: begin
        if (mode_sel[MODE_EN]) begin
          state_nxt = ST_QFIX;
        end else begin
          chan_done = 1'b1;
        end
      end
      ST_QFIX: begin
        n_nxt = quot;
        if (quot == '0) begin
          chan_done = 1'b1;
        end else begin
          state_nxt = ST_BUMP;
        end
      end
      ST_BUMP: begin
        wr_cnt_en  = 1'b1;
        wr_cnt_val = bump_cnt;
        irq_v      = irq_r | (bump_irq ? irq_bit : 3'b000);
        irq_nxt    = irq_v;
        n_nxt      = n_r - 10'd1;
        if (n_r == 10'd1) begin
          chan_done = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // advance to the next channel or finish the tick
    if (chan_done) begin
      if (ch_r == NUM_CHAN_LAST) begin
        state_nxt             = ST_IDLE;
        out_valid_nxt         = 1'b1;
        out_res_nxt.irq_lines = irq_v;
      end else begin
        ch_nxt    = ch_r + 2'd1;
        state_nxt = ST_QMUL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r      <= ch_nxt;
    n_r       <= n_nxt;
    cyc_r     <= cyc_nxt;
    irq_r     <= irq_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cnt_r[i]  <= '0;
        tgt_r[i]  <= '0;
        mode_r[i] <= '0;
      end
    end else begin
      if (wr_cnt_en) begin
        cnt_r[sel_idx] <= wr_cnt_val;
      end
      if (wr_tgt_en) begin
        tgt_r[sel_idx] <= in_req.write_data;
      end
      if (wr_mode_en) begin
        mode_r[sel_idx] <= in_req.write_data[12:0] & MODE_WR_MASK;
      end
    end
  end

  `RCNT_ASSERT(a_tick_goes_busy, (start && !busy && in_req.command == CMD_TICK) |=> busy, "tick request did not start the sequencer")
  `RCNT_ASSERT(a_bump_enabled, (state_r == ST_BUMP) |-> (mode_sel[MODE_EN] && n_r != '0), "increment on a disabled channel or with no steps left")
  `RCNT_ASSERT(a_done_gives_result, $fell(busy) |-> out_valid, "tick finished without a result")
  `RCNT_ASSERT_NEVER(a_no_write_chan3, (wr_cnt_en || wr_tgt_en || wr_mode_en) && !ch_ok, "register write to channel three")

endmodule
